FILE: design/saa_pkg.sv
// Shared types and constants for the stack arena allocator.
// Holds command, status and state encodings plus arena geometry constants.
// No dependencies.
`default_nettype none
package saa_pkg;

  localparam int ARENA_BYTES   = 65536;
  localparam int HEADER_BYTES  = 8;
  localparam int MAX_BLOCKS    = 256;
  localparam int DEFAULT_ALIGN = 16;
  localparam int WORD_BYTES    = 8;
  localparam int HDR_DEPTH     = ARENA_BYTES / HEADER_BYTES;
  localparam int HDR_AW        = $clog2(HDR_DEPTH);
  localparam int DEF_AW        = $clog2(MAX_BLOCKS);

  typedef enum logic [2:0] {
    CMD_ALIGNED = 3'd0,
    CMD_ALLOC   = 3'd1,
    CMD_ZEROED  = 3'd2,
    CMD_FREE    = 3'd3,
    CMD_RESIZE  = 3'd4,
    CMD_RESET   = 3'd5,
    CMD_RESTORE = 3'd6,
    CMD_UNUSED  = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_ALIGN_POW2 = 4'd1,
    ST_ALIGN_WORD = 4'd2,
    ST_BAD_SIZE   = 4'd3,
    ST_NO_SPACE   = 4'd4,
    ST_INVALID    = 4'd5,
    ST_NULL       = 4'd6,
    ST_DEFERRED   = 4'd7,
    ST_CASCADE    = 4'd8,
    ST_TABLE_FULL = 4'd9
  } status_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CALC  = 6'b000100,
    S_DREAD = 6'b001000,
    S_NREAD = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

endpackage
`default_nettype wire

FILE: design/saa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module saa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: design/stack_arena_allocator_deferred_free.sv
// Each command passes S_IDLE (accept, header read), S_CALC (decision) and S_FIN
// (result loaded when the output is free). A cascading free adds S_DREAD (table
// read) then S_NREAD (header read) per deferred entry taken, or S_DREAD alone
// when the taken offset is out of range. No new input beat is taken until the
// result is loaded. After reset all 8192 header RAM entries are swept to zero;
// no input beat is taken until the sweep ends. Depends on saa_pkg and saa_ram.
`default_nettype none
module stack_arena_allocator_deferred_free (
  input  logic        clk,
  input  logic        rst_n,
  // alignment, req_size, element_count, block_offset, restore_count,
  // restore_index (lowest bit up), zero padded
  input  logic [95:0] in_tdata,
  // command, block_is_null (lowest bit up)
  input  logic [3:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // status, result_offset, zero_fill_bytes, released_blocks, alloc_count,
  // stack_top (lowest bit up)
  output logic [71:0] out_tdata,
  // result_is_null
  output logic        out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);
  import saa_pkg::*;

  state_t state_r, state_nxt;
  logic [HDR_AW-1:0] clr_r;
  logic [16:0] cap_cfg_r, cap;
  logic [16:0] top_r, top_nxt;
  logic [8:0]  cnt_r, cnt_nxt, pend_r, pend_nxt;
  logic [MAX_BLOCKS-1:0] dval_r, dval_nxt;

  cmd_t        cmd_r;
  logic [16:0] align_r, size_r, count_r, ri_r;
  logic [15:0] off_r;
  logic        null_r;
  logic [8:0]  rc_r;
  logic [33:0] prod_r;

  status_t     res_status_r, res_status_nxt;
  logic [15:0] res_off_r, res_off_nxt;
  logic        res_null_r, res_null_nxt;
  logic [16:0] res_fill_r, res_fill_nxt;
  logic [8:0]  res_rel_r, res_rel_nxt;
  logic        res_free_r, res_free_nxt;

  logic [71:0] out_tdata_r;
  logic        out_null_r, out_tvalid_r;

  logic              accept, out_load;
  logic [15:0]       in_off;
  logic              h_we;
  logic [HDR_AW-1:0] h_waddr, h_raddr;
  logic [8:0]        h_wdata, hdr;
  logic              d_we;
  logic [DEF_AW-1:0] d_waddr, d_raddr;
  logic [15:0]       d_rdata;

  logic [DEF_AW-1:0] enq_idx, take_idx;
  logic              h_ok, off_ok, nxt_ok, cont;
  logic [16:0]       pop_top;
  logic [17:0]       rsize;
  logic [34:0]       rtotal;
  logic [34:0]       a_size;
  logic [35:0]       a_end;
  logic [18:0]       rs_end;
  logic              c_alloc, c_inplace, c_pop, c_enq;
  status_t           c_status, fin_status;
  logic [8:0]        rc_sat;
  logic [16:0]       ri_sat;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_off    = in_tdata[66:51];

  assign cap = (cap_cfg_r > 17'(ARENA_BYTES - DEFAULT_ALIGN)) ? 17'(ARENA_BYTES)
             : ((cap_cfg_r + 17'(DEFAULT_ALIGN - 1)) & ~17'(DEFAULT_ALIGN - 1));

  saa_ram #(.WIDTH(9), .DEPTH(HDR_DEPTH)) u_hdr_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(hdr)
  );

  saa_ram #(.WIDTH(16), .DEPTH(MAX_BLOCKS)) u_def_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(off_r),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  // The header of a block sits in the entry just below its data offset.
  assign h_raddr = (state_r == S_DREAD) ? (d_rdata[15:3] - HDR_AW'(1))
                                        : (in_off[15:3] - HDR_AW'(1));

  assign h_ok     = (hdr != 9'd0) && (hdr <= cnt_r);
  assign enq_idx  = hdr[DEF_AW-1:0] - DEF_AW'(1);
  assign take_idx = hdr[DEF_AW-1:0] - DEF_AW'(2);
  assign d_waddr  = enq_idx;
  assign d_raddr  = take_idx;
  assign off_ok   = (off_r >= 16'(HEADER_BYTES)) && ({1'b0, off_r} < top_r)
                 && (off_r[2:0] == 3'd0);
  assign nxt_ok   = (d_rdata >= 16'(HEADER_BYTES)) && ({1'b0, d_rdata} < top_r)
                 && (d_rdata[2:0] == 3'd0);
  assign cont     = (pend_r != 9'd0) && (hdr >= 9'd2) && dval_r[take_idx];
  assign pop_top  = {1'b0, off_r} - 17'(HEADER_BYTES);

  assign rsize  = ({1'b0, size_r} + 18'(DEFAULT_ALIGN - 1)) & ~18'(DEFAULT_ALIGN - 1);
  assign rtotal = ({1'b0, prod_r} + 35'(DEFAULT_ALIGN - 1)) & ~35'(DEFAULT_ALIGN - 1);
  assign a_end  = {19'd0, top_r} + 36'(HEADER_BYTES) + {1'b0, a_size};
  assign rs_end = {3'd0, off_r} + {1'b0, rsize};
  assign rc_sat = (rc_r > 9'(MAX_BLOCKS)) ? 9'(MAX_BLOCKS) : rc_r;
  assign ri_sat = (ri_r > cap) ? cap : ri_r;

  // Command decode, valid in the decision cycle once the header is back.
  always_comb begin
    c_alloc   = 1'b0;
    c_inplace = 1'b0;
    c_pop     = 1'b0;
    c_enq     = 1'b0;
    c_status  = ST_OK;
    a_size    = {17'd0, rsize};
    unique case (cmd_r)
      CMD_ALIGNED: begin
        a_size = {18'd0, size_r};
        if (align_r == 17'd0 || (align_r & (align_r - 17'd1)) != 17'd0) begin
          c_status = ST_ALIGN_POW2;
        end else if (align_r[2:0] != 3'd0) begin
          c_status = ST_ALIGN_WORD;
        end else if (size_r == 17'd0 || (size_r & (align_r - 17'd1)) != 17'd0) begin
          c_status = ST_BAD_SIZE;
        end else begin
          c_alloc = 1'b1;
        end
      end
      CMD_ALLOC: begin
        if (size_r == 17'd0) c_status = ST_BAD_SIZE;
        else c_alloc = 1'b1;
      end
      CMD_ZEROED: begin
        a_size = rtotal;
        if (count_r == 17'd0 || size_r == 17'd0) c_status = ST_BAD_SIZE;
        else c_alloc = 1'b1;
      end
      CMD_FREE: begin
        if (null_r) c_status = ST_NULL;
        else if (!(off_ok && h_ok)) c_status = ST_INVALID;
        else if (hdr == cnt_r) c_pop = 1'b1;
        else c_enq = 1'b1;
      end
      CMD_RESIZE: begin
        if (null_r) begin
          if (size_r == 17'd0) c_status = ST_BAD_SIZE;
          else c_alloc = 1'b1;
        end else if (!(off_ok && h_ok)) begin
          c_status = ST_INVALID;
        end else if (hdr == cnt_r) begin
          c_inplace = 1'b1;
        end else if (size_r == 17'd0) begin
          c_status = ST_BAD_SIZE;
        end else begin
          c_alloc = 1'b1;
        end
      end
      CMD_RESET, CMD_RESTORE: c_status = ST_OK;
      default: c_status = ST_INVALID;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    dval_nxt       = dval_r;
    h_we           = 1'b0;
    h_waddr        = top_r[15:3];
    h_wdata        = cnt_r + 9'd1;
    d_we           = 1'b0;
    res_status_nxt = res_status_r;
    res_off_nxt    = res_off_r;
    res_null_nxt   = res_null_r;
    res_fill_nxt   = res_fill_r;
    res_rel_nxt    = res_rel_r;
    res_free_nxt   = res_free_r;
    unique case (state_r)
      S_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = clr_r;
        h_wdata = 9'd0;
        if (&clr_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_CALC;
      end
      S_CALC: begin
        state_nxt      = S_FIN;
        res_status_nxt = c_status;
        res_off_nxt    = 16'd0;
        res_null_nxt   = 1'b1;
        res_fill_nxt   = 17'd0;
        res_rel_nxt    = 9'd0;
        res_free_nxt   = 1'b0;
        if (c_alloc) begin
          if (cnt_r >= 9'(MAX_BLOCKS)) begin
            res_status_nxt = ST_TABLE_FULL;
          end else if (a_end >= {19'd0, cap}) begin
            res_status_nxt = ST_NO_SPACE;
          end else begin
            h_we         = 1'b1;
            cnt_nxt      = cnt_r + 9'd1;
            top_nxt      = a_end[16:0];
            res_off_nxt  = top_r[15:0] + 16'(HEADER_BYTES);
            res_null_nxt = 1'b0;
            if (cmd_r == CMD_ZEROED) res_fill_nxt = rtotal[16:0];
          end
        end
        if (c_inplace) begin
          if (rs_end >= {2'd0, cap}) begin
            res_status_nxt = ST_NO_SPACE;
          end else begin
            top_nxt      = rs_end[16:0];
            res_off_nxt  = off_r;
            res_null_nxt = 1'b0;
          end
        end
        if (c_enq) begin
          d_we           = 1'b1;
          res_status_nxt = ST_DEFERRED;
          if (!dval_r[enq_idx]) begin
            dval_nxt[enq_idx] = 1'b1;
            pend_nxt          = pend_r + 9'd1;
          end
        end
        if (c_pop) begin
          top_nxt      = pop_top;
          cnt_nxt      = cnt_r - 9'd1;
          res_rel_nxt  = 9'd1;
          res_free_nxt = 1'b1;
          if (cont) begin
            dval_nxt[take_idx] = 1'b0;
            pend_nxt           = pend_r - 9'd1;
            state_nxt          = S_DREAD;
          end
        end
        if (cmd_r == CMD_RESET) begin
          top_nxt = 17'd0;
          cnt_nxt = 9'd0;
        end
        if (cmd_r == CMD_RESTORE) begin
          cnt_nxt = rc_sat;
          top_nxt = {ri_sat[16:3], 3'd0};
        end
      end
      S_DREAD: begin
        // The next block's offset is on the table read port; off_r takes it.
        if (nxt_ok) state_nxt = S_NREAD;
        else state_nxt = S_FIN;
      end
      S_NREAD: begin
        state_nxt = S_FIN;
        if (h_ok && hdr != cnt_r) begin
          d_we = 1'b1;
          if (!dval_r[enq_idx]) begin
            dval_nxt[enq_idx] = 1'b1;
            pend_nxt          = pend_r + 9'd1;
          end
        end else if (h_ok) begin
          top_nxt     = pop_top;
          cnt_nxt     = cnt_r - 9'd1;
          res_rel_nxt = res_rel_r + 9'd1;
          if (cont) begin
            dval_nxt[take_idx] = 1'b0;
            pend_nxt           = pend_r - 9'd1;
            state_nxt          = S_DREAD;
          end
        end
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_load   = (state_r == S_FIN) && (!out_tvalid_r || out_tready);
  assign fin_status = res_free_r ? ((pend_r != 9'd0) ? ST_CASCADE : ST_OK) : res_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      cap_cfg_r    <= 17'(ARENA_BYTES);
      top_r        <= 17'd0;
      cnt_r        <= 9'd0;
      pend_r       <= 9'd0;
      dval_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      dval_r  <= dval_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + HDR_AW'(1);
      if (cfg_we) cap_cfg_r <= cfg_wdata;
      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= cmd_t'(in_tuser[2:0]);
      null_r  <= in_tuser[3];
      align_r <= in_tdata[16:0];
      size_r  <= in_tdata[33:17];
      count_r <= in_tdata[50:34];
      off_r   <= in_off;
      rc_r    <= in_tdata[75:67];
      ri_r    <= in_tdata[92:76];
      prod_r  <= in_tdata[50:34] * in_tdata[33:17];
    end else if (state_r == S_DREAD) begin
      off_r <= d_rdata;
    end
    res_status_r <= res_status_nxt;
    res_off_r    <= res_off_nxt;
    res_null_r   <= res_null_nxt;
    res_fill_r   <= res_fill_nxt;
    res_rel_r    <= res_rel_nxt;
    res_free_r   <= res_free_nxt;
    if (out_load) begin
      out_tdata_r <= {top_r, cnt_r, res_rel_r, res_fill_r, res_off_r, fin_status};
      out_null_r  <= res_null_r;
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_null_r;
  assign out_tvalid = out_tvalid_r;

`ifndef NO_ASSERTIONS
  // The pending count always matches the number of queued table entries.
  a_pend_matches: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 9'($countones(dval_r)))
    else $error("pending count out of step with table valid bits");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 9'(MAX_BLOCKS))
    else $error("allocation counter above limit");

  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= 17'(ARENA_BYTES))
    else $error("stack top beyond arena");

  // A cascade step that finds the top block pops exactly one block.
  a_cascade_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NREAD && h_ok && hdr == cnt_r) |=> (cnt_r == $past(cnt_r) - 9'd1))
    else $error("cascade pop did not decrement the counter");
`endif

endmodule
`default_nettype wire
